>>> rtl/sjf_pkg.sv
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared widths, codes and types for the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

   localparam int MAX_JOBS_DEF = 16;

   localparam int CMD_W  = 1;
   localparam int ARR_W  = 16;
   localparam int BUR_W  = 12;
   localparam int ID_W   = 8;
   localparam int TIME_W = 17;

   // one stored job: arrival, burst, id
   localparam int ENTRY_W = ARR_W + BUR_W + ID_W;

   localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_WAIT  = 5'b10000
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_we;     // write one job into the store
      logic scan_clear;  // forget both candidates before a scan
      logic eval;        // store read data is valid, compare it
      logic emit;        // capture the chosen job as a result
      logic emit_last;   // result closes the schedule
      logic batch_clear; // drop finished flags and time
   } ctl_cmd_type;

endpackage

>>> rtl/sjf_ram.sv
// ----------------------------------------------------------------------------
// sjf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sjf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/sjf_datapath.sv
// ----------------------------------------------------------------------------
// sjf_datapath
// Job store, finished flags, scan compare, schedule clock and result register.
// ----------------------------------------------------------------------------
module sjf_datapath #(
   parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  sjf_pkg::ctl_cmd_type                               cmd,
   input  logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] wr_addr,
   input  logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] rd_addr,
   input  logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] eval_idx,
   input  logic [sjf_pkg::ARR_W-1:0]                          req_arrival_time,
   input  logic [sjf_pkg::BUR_W-1:0]                          req_burst_time,
   input  logic [sjf_pkg::ID_W-1:0]                           req_job_id,
   output logic [sjf_pkg::ID_W-1:0]                           rsp_done_id,
   output logic [sjf_pkg::TIME_W-1:0]                         rsp_start_time,
   output logic [sjf_pkg::TIME_W-1:0]                         rsp_completion_time,
   output logic [sjf_pkg::TIME_W-1:0]                         rsp_turnaround,
   output logic [sjf_pkg::TIME_W-1:0]                         rsp_waiting,
   output logic [sjf_pkg::TIME_W-1:0]                         rsp_response,
   output logic                                               rsp_last_result
);

   localparam int IDX_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int ARR_W   = sjf_pkg::ARR_W;
   localparam int BUR_W   = sjf_pkg::BUR_W;
   localparam int ID_W    = sjf_pkg::ID_W;
   localparam int TIME_W  = sjf_pkg::TIME_W;
   localparam int ENTRY_W = sjf_pkg::ENTRY_W;

   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [BUR_W-1:0]   load_bur;

   logic [ARR_W-1:0]   rd_arr;
   logic [BUR_W-1:0]   rd_bur;
   logic [ID_W-1:0]    rd_id;
   logic               is_fin;
   logic               is_ready;
   logic               rdy_better;
   logic               early_better;

   logic [MAX_JOBS-1:0] fin_ff;
   logic [TIME_W-1:0]   time_ff;

   // best ready job of the scan
   logic               rdy_have_ff;
   logic [ARR_W-1:0]   rdy_arr_ff;
   logic [BUR_W-1:0]   rdy_bur_ff;
   logic [ID_W-1:0]    rdy_id_ff;
   logic [IDX_W-1:0]   rdy_idx_ff;
   // earliest pending job, used when nothing has arrived yet
   logic               early_have_ff;
   logic [ARR_W-1:0]   early_arr_ff;
   logic [BUR_W-1:0]   early_bur_ff;
   logic [ID_W-1:0]    early_id_ff;
   logic [IDX_W-1:0]   early_idx_ff;

   logic [ARR_W-1:0]   sel_arr;
   logic [BUR_W-1:0]   sel_bur;
   logic [ID_W-1:0]    sel_id;
   logic [IDX_W-1:0]   sel_idx;
   logic [TIME_W-1:0]  start_t;
   logic [TIME_W-1:0]  end_t;
   logic [TIME_W-1:0]  resp_t;
   logic [TIME_W-1:0]  turn_t;

   // a zero burst runs for one tick
   assign load_bur = (req_burst_time == '0) ? BUR_W'(1) : req_burst_time;
   assign wr_data  = {req_arrival_time, load_bur, req_job_id};

   sjf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_JOBS)
   ) u_store (
      .clock (clock),
      .we    (cmd.load_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   always_comb begin
      rd_arr = rd_data[ENTRY_W-1 -: ARR_W];
      rd_bur = rd_data[ID_W +: BUR_W];
      rd_id  = rd_data[ID_W-1:0];
      is_fin   = fin_ff[eval_idx];
      is_ready = !is_fin && ({1'b0, rd_arr} <= time_ff);
      // shorter burst, then earlier arrival, then smaller id
      rdy_better   = !rdy_have_ff ||
                     ({rd_bur, rd_arr, rd_id} < {rdy_bur_ff, rdy_arr_ff, rdy_id_ff});
      early_better = !early_have_ff ||
                     ({rd_arr, rd_bur, rd_id} < {early_arr_ff, early_bur_ff, early_id_ff});
   end

   always_comb begin
      if (rdy_have_ff) begin
         sel_arr = rdy_arr_ff;
         sel_bur = rdy_bur_ff;
         sel_id  = rdy_id_ff;
         sel_idx = rdy_idx_ff;
         start_t = time_ff;
      end else begin
         // idle gap: jump to the earliest pending arrival
         sel_arr = early_arr_ff;
         sel_bur = early_bur_ff;
         sel_id  = early_id_ff;
         sel_idx = early_idx_ff;
         start_t = TIME_W'(early_arr_ff);
      end
      end_t  = start_t + TIME_W'(sel_bur);
      resp_t = start_t - TIME_W'(sel_arr);
      turn_t = end_t - TIME_W'(sel_arr);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.scan_clear) begin
         rdy_have_ff   <= 1'b0;
         early_have_ff <= 1'b0;
      end else if (cmd.eval) begin
         if (is_ready && rdy_better) begin
            rdy_have_ff <= 1'b1;
         end
         if (!is_fin && early_better) begin
            early_have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval && is_ready && rdy_better) begin
         rdy_arr_ff <= rd_arr;
         rdy_bur_ff <= rd_bur;
         rdy_id_ff  <= rd_id;
         rdy_idx_ff <= eval_idx;
      end
      if (cmd.eval && !is_fin && early_better) begin
         early_arr_ff <= rd_arr;
         early_bur_ff <= rd_bur;
         early_id_ff  <= rd_id;
         early_idx_ff <= eval_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.batch_clear) begin
         fin_ff  <= '0;
         time_ff <= '0;
      end else if (cmd.emit) begin
         fin_ff[sel_idx] <= 1'b1;
         time_ff         <= end_t;
      end
   end

   // result register, held until the transaction completes
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_done_id         <= sel_id;
         rsp_start_time      <= start_t;
         rsp_completion_time <= end_t;
         rsp_turnaround      <= turn_t;
         rsp_waiting         <= resp_t;
         rsp_response        <= resp_t;
         rsp_last_result     <= cmd.emit_last;
      end
   end

endmodule

>>> rtl/sjf_controller.sv
// ----------------------------------------------------------------------------
// sjf_controller
// Load, scan, emit sequencer with job, scan and done counters.
// ----------------------------------------------------------------------------
module sjf_controller #(
   parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               req_valid,
   output logic                                               req_ready,
   input  logic [sjf_pkg::CMD_W-1:0]                          req_command,
   input  logic                                               req_last_job,
   output logic                                               rsp_valid,
   input  logic                                               rsp_ready,
   output sjf_pkg::ctl_cmd_type                               cmd,
   output logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] wr_addr,
   output logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] rd_addr,
   output logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] eval_idx
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_JOBS);

   sjf_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   done_ff, done_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic               eval_ff, eval_in;
   logic [IDX_W-1:0]   eval_idx_ff;
   logic               accept_load;
   logic               scan_end;
   logic               last_out;

   assign accept_load = req_valid && req_ready && (req_command == sjf_pkg::CMD_LOAD);
   assign scan_end    = (CNT_W'(scan_ff) + CNT_W'(1)) == count_ff;
   assign last_out    = (done_ff + CNT_W'(1)) == count_ff;

   assign req_ready = (state_ff == sjf_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == sjf_pkg::ST_WAIT);
   assign wr_addr   = count_ff[IDX_W-1:0];
   assign rd_addr   = scan_ff;
   assign eval_idx  = eval_idx_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      done_in  = done_ff;
      scan_in  = scan_ff;
      eval_in  = 1'b0;
      cmd      = '0;
      cmd.eval = eval_ff;
      case (state_ff)
         sjf_pkg::ST_IDLE: begin
            if (accept_load) begin
               // drop the job when the store is full
               if (count_ff < MaxCount) begin
                  cmd.load_we = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
               end
               if (req_last_job) begin
                  cmd.scan_clear = 1'b1;
                  scan_in        = '0;
                  state_in       = sjf_pkg::ST_SCAN;
               end
            end
         end
         sjf_pkg::ST_SCAN: begin
            eval_in = 1'b1;
            if (scan_end) begin
               state_in = sjf_pkg::ST_DRAIN;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         sjf_pkg::ST_DRAIN: begin
            state_in = sjf_pkg::ST_EMIT;
         end
         sjf_pkg::ST_EMIT: begin
            cmd.emit      = 1'b1;
            cmd.emit_last = last_out;
            done_in       = done_ff + CNT_W'(1);
            state_in      = sjf_pkg::ST_WAIT;
         end
         sjf_pkg::ST_WAIT: begin
            if (rsp_ready) begin
               if (done_ff == count_ff) begin
                  cmd.batch_clear = 1'b1;
                  count_in        = '0;
                  done_in         = '0;
                  state_in        = sjf_pkg::ST_IDLE;
               end else begin
                  cmd.scan_clear = 1'b1;
                  scan_in        = '0;
                  state_in       = sjf_pkg::ST_SCAN;
               end
            end
         end
         default: begin
            state_in = sjf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sjf_pkg::ST_IDLE;
         count_ff <= '0;
         done_ff  <= '0;
         scan_ff  <= '0;
         eval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
         scan_ff  <= scan_in;
         eval_ff  <= eval_in;
      end
   end

   // index of the entry whose registered read data is being evaluated
   always_ff @(posedge clock) begin
      eval_idx_ff <= scan_ff;
   end

endmodule

>>> rtl/sjf_nonpreemptive_scheduler_top.sv
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler_top
// Non-preemptive shortest-job-first scheduler over a batch of loaded jobs.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  command, arrival, burst, id, last
//   rsp      out        rsp_valid / rsp_ready  id, start, completion, metrics, last
//
// Each scheduling decision scans the job store through its single read port,
// one entry a cycle, and each result is held while rsp_ready stays low. Loads
// are refused while a batch is being scheduled. Reset is synchronous and
// empties the batch; the store needs no clearing pass since only loaded
// entries are read.
// ----------------------------------------------------------------------------
module sjf_nonpreemptive_scheduler_top #(
   parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [sjf_pkg::CMD_W-1:0]   req_command,
   input  logic [sjf_pkg::ARR_W-1:0]   req_arrival_time,
   input  logic [sjf_pkg::BUR_W-1:0]   req_burst_time,
   input  logic [sjf_pkg::ID_W-1:0]    req_job_id,
   input  logic                        req_last_job,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sjf_pkg::ID_W-1:0]    rsp_done_id,
   output logic [sjf_pkg::TIME_W-1:0]  rsp_start_time,
   output logic [sjf_pkg::TIME_W-1:0]  rsp_completion_time,
   output logic [sjf_pkg::TIME_W-1:0]  rsp_turnaround,
   output logic [sjf_pkg::TIME_W-1:0]  rsp_waiting,
   output logic [sjf_pkg::TIME_W-1:0]  rsp_response,
   output logic                        rsp_last_result
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

   sjf_pkg::ctl_cmd_type cmd;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     eval_idx;

   sjf_controller #(
      .MAX_JOBS (MAX_JOBS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_last_job (req_last_job),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .eval_idx     (eval_idx)
   );

   sjf_datapath #(
      .MAX_JOBS (MAX_JOBS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .wr_addr             (wr_addr),
      .rd_addr             (rd_addr),
      .eval_idx            (eval_idx),
      .req_arrival_time    (req_arrival_time),
      .req_burst_time      (req_burst_time),
      .req_job_id          (req_job_id),
      .rsp_done_id         (rsp_done_id),
      .rsp_start_time      (rsp_start_time),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround      (rsp_turnaround),
      .rsp_waiting         (rsp_waiting),
      .rsp_response        (rsp_response),
      .rsp_last_result     (rsp_last_result)
   );

   // no load is taken while a result is pending
   a_no_load_during_rsp : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready
   ) else $error("load port open while a result is pending");

   // the closing transaction of a schedule returns the block to loading
   a_last_returns_idle : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_result) |=> (req_ready && !rsp_valid)
   ) else $error("block did not return to loading after the last result");

   // a batch-closing load starts scheduling
   a_last_job_starts : assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_command == sjf_pkg::CMD_LOAD) && req_last_job)
         |=> !req_ready
   ) else $error("scheduling did not start after the last job");

   // a non-final result is followed by further work, not by loading
   a_more_results : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_result) |=> !req_ready
   ) else $error("schedule ended early");

endmodule
